FILE: src/mips5_pkg.sv
// ----------------------------------------------------------------------------
// MIPS five-stage pipeline package
// Shared constants, instruction codes and structure types for the pipeline.
// ----------------------------------------------------------------------------
package mips5_pkg;

   localparam int DMEM_BYTES = 256;
   localparam int DMEM_AW    = $clog2(DMEM_BYTES);
   localparam int DMEM_ROWS  = DMEM_BYTES / 4;
   localparam int DMEM_RW    = DMEM_AW - 2;

   localparam logic        REQ_RUN     = 1'b0;
   localparam logic        REQ_PRELOAD = 1'b1;

   localparam logic [5:0]  OPC_RTYPE = 6'h00;
   localparam logic [5:0]  OPC_LW    = 6'h23;
   localparam logic [5:0]  OPC_SW    = 6'h2B;
   localparam logic [5:0]  FN_SUBU   = 6'h23;
   localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;
   localparam logic [31:0] PC_STEP   = 32'd4;

   typedef struct packed {
      logic        en;
      logic [4:0]  idx;
      logic [31:0] data;
   } rf_wr_type;

   typedef struct packed {
      logic               rd;
      logic               wr;
      logic               pl;
      logic [DMEM_AW-1:0] addr;
      logic [31:0]        wdata;
   } dmem_cmd_type;

   typedef struct packed {
      logic [31:0] fetch_pc;
      logic        halted;
      logic        reg_write_valid;
      logic [4:0]  reg_write_index;
      logic [31:0] reg_write_data;
      logic        mem_write_valid;
      logic [7:0]  mem_write_address;
      logic [31:0] mem_write_data;
   } rsp_type;

endpackage

FILE: src/mips_five_stage_pipeline_core.sv
// ----------------------------------------------------------------------------
// MIPS five-stage pipeline core
// Fetch, decode, execute, memory and write-back stages for addu, subu, lw
// and sw, without forwarding or stalls. Each run request advances every
// stage of the pipeline; each preload request writes one data memory byte.
// Each accepted request's result passes through the result buffer before it is presented.
// Throughput: one request per cycle while the result buffer is not full; a two-entry result buffer absorbs stalls.
// Reset clears the program counter, stage valid bits, register file and data
// memory valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module mips_five_stage_pipeline_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [31:0] req_instr_word,
   input  logic [7:0]  req_load_address,
   input  logic [7:0]  req_load_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_fetch_pc,
   output logic        rsp_halted,
   output logic        rsp_reg_write_valid,
   output logic [4:0]  rsp_reg_write_index,
   output logic [31:0] rsp_reg_write_data,
   output logic        rsp_mem_write_valid,
   output logic [7:0]  rsp_mem_write_address,
   output logic [31:0] rsp_mem_write_data
);
   import mips5_pkg::*;

   logic         req_accept;
   logic         run;
   logic         preload;

   logic [31:0]  pc_ff, pc_in;
   logic         stop_ff, stop_in;
   logic         dec_vld_ff, dec_vld_in;
   logic [31:0]  dec_instr_ff, dec_instr_in;

   logic         ex_vld_ff, ex_vld_in;
   logic [15:0]  ex_imm_ff, ex_imm_in;
   logic [4:0]   ex_dest_ff, ex_dest_in;
   logic         ex_is_imm_ff, ex_is_imm_in;
   logic         ex_rd_ff, ex_rd_in;
   logic         ex_wr_ff, ex_wr_in;
   logic         ex_add_ff, ex_add_in;
   logic         ex_rw_ff, ex_rw_in;

   logic         mem_vld_ff, mem_vld_in;
   logic [31:0]  mem_alu_ff, mem_alu_in;
   logic [31:0]  mem_store_ff, mem_store_in;
   logic [4:0]   mem_dest_ff, mem_dest_in;
   logic         mem_rd_ff, mem_rd_in;
   logic         mem_wr_ff, mem_wr_in;
   logic         mem_rw_ff, mem_rw_in;

   logic         wb_vld_ff, wb_vld_in;
   logic [31:0]  wb_data_ff, wb_data_in;
   logic [4:0]   wb_dest_ff, wb_dest_in;
   logic         wb_rw_ff, wb_rw_in;
   logic         wb_ld_ff, wb_ld_in;

   logic [5:0]   dec_op;
   logic [5:0]   dec_fn;
   logic [4:0]   dec_rs;
   logic [4:0]   dec_rt;
   logic [4:0]   dec_rd;

   logic [31:0]  rf_rd1;
   logic [31:0]  rf_rd2;
   rf_wr_type    rf_wr;
   logic [31:0]  alu_b;
   logic [31:0]  alu_out;
   logic         wb_we;
   logic [31:0]  wb_word;
   logic [31:0]  dmem_rd_word;
   dmem_cmd_type dmem_cmd;
   rsp_type      rsp_new;
   rsp_type      rsp_out;

   assign req_accept = req_valid && !req_stall;
   assign run        = req_accept && req_opcode == REQ_RUN;
   assign preload    = req_accept && req_opcode == REQ_PRELOAD;

   assign dec_op = dec_instr_ff[31:26];
   assign dec_fn = dec_instr_ff[5:0];
   assign dec_rs = dec_instr_ff[25:21];
   assign dec_rt = dec_instr_ff[20:16];
   assign dec_rd = dec_instr_ff[15:11];

   assign wb_we   = wb_vld_ff && wb_rw_ff && wb_dest_ff != 5'd0;
   assign wb_word = wb_ld_ff ? dmem_rd_word : wb_data_ff;

   assign rf_wr.en   = run && wb_we;
   assign rf_wr.idx  = wb_dest_ff;
   assign rf_wr.data = wb_word;

   assign alu_b   = ex_is_imm_ff ? {{16{ex_imm_ff[15]}}, ex_imm_ff} : rf_rd2;
   assign alu_out = ex_add_ff ? rf_rd1 + alu_b : rf_rd1 - alu_b;

   assign dmem_cmd.rd    = run && mem_vld_ff && mem_rd_ff;
   assign dmem_cmd.wr    = run && mem_vld_ff && !mem_rd_ff && mem_wr_ff;
   assign dmem_cmd.pl    = preload;
   assign dmem_cmd.addr  = preload ? DMEM_AW'(req_load_address)
                                   : mem_alu_ff[DMEM_AW-1:0];
   assign dmem_cmd.wdata = preload ? {24'd0, req_load_byte} : mem_store_ff;

   mips5_regfile u_regfile (
      .clock (clock),
      .reset (reset),
      .wr    (rf_wr),
      .rd_en (run && dec_vld_ff),
      .rs    (dec_rs),
      .rt    (dec_rt),
      .rd1   (rf_rd1),
      .rd2   (rf_rd2)
   );

   mips5_dmem u_dmem (
      .clock   (clock),
      .reset   (reset),
      .cmd     (dmem_cmd),
      .rd_word (dmem_rd_word)
   );

   always_comb begin
      pc_in        = pc_ff;
      stop_in      = stop_ff;
      dec_vld_in   = dec_vld_ff;
      dec_instr_in = dec_instr_ff;
      ex_vld_in    = ex_vld_ff;
      ex_imm_in    = ex_imm_ff;
      ex_dest_in   = ex_dest_ff;
      ex_is_imm_in = ex_is_imm_ff;
      ex_rd_in     = ex_rd_ff;
      ex_wr_in     = ex_wr_ff;
      ex_add_in    = ex_add_ff;
      ex_rw_in     = ex_rw_ff;
      mem_vld_in   = mem_vld_ff;
      mem_alu_in   = mem_alu_ff;
      mem_store_in = mem_store_ff;
      mem_dest_in  = mem_dest_ff;
      mem_rd_in    = mem_rd_ff;
      mem_wr_in    = mem_wr_ff;
      mem_rw_in    = mem_rw_ff;
      wb_vld_in    = wb_vld_ff;
      wb_data_in   = wb_data_ff;
      wb_dest_in   = wb_dest_ff;
      wb_rw_in     = wb_rw_ff;
      wb_ld_in     = wb_ld_ff;
      if (run) begin
         wb_vld_in = mem_vld_ff;
         if (mem_vld_ff) begin
            wb_data_in = mem_alu_ff;
            wb_dest_in = mem_dest_ff;
            wb_rw_in   = mem_rw_ff;
            wb_ld_in   = mem_rd_ff;
         end
         mem_vld_in = ex_vld_ff;
         if (ex_vld_ff) begin
            mem_alu_in   = alu_out;
            mem_store_in = rf_rd2;
            mem_dest_in  = ex_dest_ff;
            mem_rd_in    = ex_rd_ff;
            mem_wr_in    = ex_wr_ff;
            mem_rw_in    = ex_rw_ff;
         end
         ex_vld_in = dec_vld_ff;
         if (dec_vld_ff) begin
            ex_imm_in    = dec_instr_ff[15:0];
            ex_is_imm_in = 1'b1;
            ex_dest_in   = dec_rt;
            ex_add_in    = 1'b1;
            ex_rd_in     = 1'b0;
            ex_wr_in     = 1'b0;
            ex_rw_in     = 1'b0;
            unique case (dec_op)
               OPC_RTYPE: begin
                  ex_is_imm_in = 1'b0;
                  ex_dest_in   = dec_rd;
                  ex_add_in    = dec_fn != FN_SUBU;
                  ex_rw_in     = 1'b1;
               end
               OPC_LW: begin
                  ex_rd_in = 1'b1;
                  ex_rw_in = 1'b1;
               end
               OPC_SW: begin
                  ex_wr_in = 1'b1;
               end
               default: begin
                  ex_rw_in = 1'b0;
               end
            endcase
         end
         if (!stop_ff) begin
            if (req_instr_word == HALT_WORD) begin
               dec_vld_in = 1'b0;
               stop_in    = 1'b1;
            end else begin
               dec_vld_in   = 1'b1;
               dec_instr_in = req_instr_word;
               pc_in        = pc_ff + PC_STEP;
            end
         end else begin
            dec_vld_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= '0;
         stop_ff    <= 1'b0;
         dec_vld_ff <= 1'b0;
         ex_vld_ff  <= 1'b0;
         mem_vld_ff <= 1'b0;
         wb_vld_ff  <= 1'b0;
      end else begin
         pc_ff      <= pc_in;
         stop_ff    <= stop_in;
         dec_vld_ff <= dec_vld_in;
         ex_vld_ff  <= ex_vld_in;
         mem_vld_ff <= mem_vld_in;
         wb_vld_ff  <= wb_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      dec_instr_ff <= dec_instr_in;
      ex_imm_ff    <= ex_imm_in;
      ex_dest_ff   <= ex_dest_in;
      ex_is_imm_ff <= ex_is_imm_in;
      ex_rd_ff     <= ex_rd_in;
      ex_wr_ff     <= ex_wr_in;
      ex_add_ff    <= ex_add_in;
      ex_rw_ff     <= ex_rw_in;
      mem_alu_ff   <= mem_alu_in;
      mem_store_ff <= mem_store_in;
      mem_dest_ff  <= mem_dest_in;
      mem_rd_ff    <= mem_rd_in;
      mem_wr_ff    <= mem_wr_in;
      mem_rw_ff    <= mem_rw_in;
      wb_data_ff   <= wb_data_in;
      wb_dest_ff   <= wb_dest_in;
      wb_rw_ff     <= wb_rw_in;
      wb_ld_ff     <= wb_ld_in;
   end

   always_comb begin
      rsp_new.fetch_pc          = pc_in;
      rsp_new.halted            = stop_in && !dec_vld_in && !ex_vld_in &&
                                  !mem_vld_in && !wb_vld_in;
      rsp_new.reg_write_valid   = rf_wr.en;
      rsp_new.reg_write_index   = rf_wr.en ? wb_dest_ff : '0;
      rsp_new.reg_write_data    = rf_wr.en ? wb_word : '0;
      rsp_new.mem_write_valid   = dmem_cmd.wr;
      rsp_new.mem_write_address = dmem_cmd.wr ? 8'(dmem_cmd.addr) : '0;
      rsp_new.mem_write_data    = dmem_cmd.wr ? mem_store_ff : '0;
   end

   mips5_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (rsp_new),
      .full      (req_stall),
      .pop_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_out)
   );

   assign rsp_fetch_pc          = rsp_out.fetch_pc;
   assign rsp_halted            = rsp_out.halted;
   assign rsp_reg_write_valid   = rsp_out.reg_write_valid;
   assign rsp_reg_write_index   = rsp_out.reg_write_index;
   assign rsp_reg_write_data    = rsp_out.reg_write_data;
   assign rsp_mem_write_valid   = rsp_out.mem_write_valid;
   assign rsp_mem_write_address = rsp_out.mem_write_address;
   assign rsp_mem_write_data    = rsp_out.mem_write_data;

   a_pc_frozen : assert property (@(posedge clock) disable iff (reset)
      stop_ff |=> $stable(pc_ff))
      else $error("program counter moved after fetch stopped");

   a_no_decode_after_halt : assert property (@(posedge clock) disable iff (reset)
      stop_ff |-> !dec_vld_ff)
      else $error("instruction decoded after fetch stopped");

   a_result_follows : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted transaction produced no result");

endmodule

FILE: src/mips5_regfile.sv
// ----------------------------------------------------------------------------
// Register file
// Thirty-two words with one write port and two registered read ports.
// A write in the same cycle is passed through to the reads.
// ----------------------------------------------------------------------------
module mips5_regfile (
   input  logic                clock,
   input  logic                reset,
   input  mips5_pkg::rf_wr_type wr,
   input  logic                rd_en,
   input  logic [4:0]          rs,
   input  logic [4:0]          rt,
   output logic [31:0]         rd1,
   output logic [31:0]         rd2
);
   import mips5_pkg::*;

   logic [31:0] mem [32];
   logic [31:0] vld_ff;
   logic [31:0] rd1_ff;
   logic [31:0] rd2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr.en) begin
         vld_ff[wr.idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && wr.idx == rs) begin
            rd1_ff <= wr.data;
         end else begin
            rd1_ff <= vld_ff[rs] ? mem[rs] : '0;
         end
         if (wr.en && wr.idx == rt) begin
            rd2_ff <= wr.data;
         end else begin
            rd2_ff <= vld_ff[rt] ? mem[rt] : '0;
         end
      end
   end

   assign rd1 = rd1_ff;
   assign rd2 = rd2_ff;

   a_no_write_r0 : assert property (@(posedge clock) disable iff (reset)
      wr.en |-> wr.idx != 5'd0)
      else $error("register zero written");

endmodule

FILE: src/mips5_dmem.sv
// ----------------------------------------------------------------------------
// Data memory
// Four byte-wide banks holding big-endian words at any byte alignment.
// Reads are registered; bytes never written read as zero.
// ----------------------------------------------------------------------------
module mips5_dmem (
   input  logic                   clock,
   input  logic                   reset,
   input  mips5_pkg::dmem_cmd_type cmd,
   output logic [31:0]            rd_word
);
   import mips5_pkg::*;

   logic [7:0] rdata [4];
   logic [1:0] a0_ff;

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         a0_ff <= cmd.addr[1:0];
      end
   end

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [7:0]           mem [DMEM_ROWS];
      logic [DMEM_ROWS-1:0] vld_ff;
      logic [7:0]           rdata_ff;
      logic [1:0]           k;
      logic [DMEM_RW-1:0]   row;
      logic                 we;
      logic [7:0]           wbyte;

      assign k     = 2'(b) - cmd.addr[1:0];
      assign row   = cmd.addr[DMEM_AW-1:2] +
                     DMEM_RW'(2'(b) < cmd.addr[1:0]);
      assign we    = cmd.wr || (cmd.pl && cmd.addr[1:0] == 2'(b));
      assign wbyte = cmd.pl ? cmd.wdata[7:0]
                            : 8'(cmd.wdata >> (5'(~k) << 3));

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= '0;
         end else if (we) begin
            vld_ff[row] <= 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (we) begin
            mem[row] <= wbyte;
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.rd) begin
            rdata_ff <= vld_ff[row] ? mem[row] : '0;
         end
      end

      assign rdata[b] = rdata_ff;
   end

   always_comb begin
      rd_word = '0;
      for (int k = 0; k < 4; k++) begin
         rd_word[8*(3-k) +: 8] = rdata[2'(a0_ff + 2'(k))];
      end
   end

   a_one_access : assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd && (cmd.wr || cmd.pl)) && !(cmd.wr && cmd.pl))
      else $error("data memory read and write in the same cycle");

endmodule

FILE: src/mips5_rsp_buf.sv
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry queue that decouples the pipeline from the result channel.
// ----------------------------------------------------------------------------
module mips5_rsp_buf (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mips5_pkg::rsp_type push_data,
   output logic               full,
   input  logic               pop_stall,
   output logic               out_valid,
   output mips5_pkg::rsp_type out_data
);
   import mips5_pkg::*;

   rsp_type    entry_ff [2];
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic       pop;

   assign out_valid = count_ff != 2'd0;
   assign full      = count_ff == 2'd2;
   assign pop       = out_valid && !pop_stall;
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer overflow");

   a_no_push_full : assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("transaction pushed into a full result buffer");

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// Five-stage pipeline core testbench
// Feeds run and preload transactions through the request channel and checks
// every response against a cycle model of the pipeline kept in this file. A
// short table of directed transactions covers loads at the top of the offset
// range, loads and stores at negative offsets, wrapping addresses, both arithmetic functions, unknown
// functions and opcodes, writes to register zero and hazards. Random
// programs follow. A halt word ends the run and is followed by ignored
// cycles and a late preload. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

   import mips5_pkg::*;

   localparam int         CYCLE_LIMIT  = 200_000;
   localparam int         RANDOM_ITEMS = 920;
   localparam int         DIRECTED     = 24;
   localparam int         DRAIN_CYCLES = 20;
   localparam logic [5:0] FN_ADDU      = 6'h21;
   localparam logic [5:0] FN_OTHER     = 6'h3F;
   localparam logic [5:0] OPC_ADDI     = 6'h08;

   typedef struct packed {
      logic        opcode;
      logic [31:0] word;
      logic [7:0]  addr;
      logic [7:0]  data;
      logic        typed;
      logic [31:0] typed_pc;
   } stim_row_type;

   typedef struct packed {
      logic        bubble;
      logic [31:0] instr;
   } dec_stage_type;

   typedef struct packed {
      logic        bubble;
      logic [31:0] opa;
      logic [31:0] opb;
      logic [15:0] imm;
      logic [4:0]  dest;
      logic        is_imm;
      logic        rd_mem;
      logic        wr_mem;
      logic        add;
      logic        wr_reg;
   } exe_stage_type;

   typedef struct packed {
      logic        bubble;
      logic [31:0] alu;
      logic [31:0] store;
      logic [4:0]  dest;
      logic        rd_mem;
      logic        wr_mem;
      logic        wr_reg;
   } mem_stage_type;

   typedef struct packed {
      logic        bubble;
      logic [31:0] data;
      logic [4:0]  dest;
      logic        wr_reg;
   } wb_stage_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_opcode;
   logic [31:0] req_instr_word;
   logic [7:0]  req_load_address;
   logic [7:0]  req_load_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_fetch_pc;
   logic        rsp_halted;
   logic        rsp_reg_write_valid;
   logic [4:0]  rsp_reg_write_index;
   logic [31:0] rsp_reg_write_data;
   logic        rsp_mem_write_valid;
   logic [7:0]  rsp_mem_write_address;
   logic [31:0] rsp_mem_write_data;

   logic [31:0]   model_pc;
   logic          model_fetch_done;
   dec_stage_type dec_q;
   exe_stage_type exe_q;
   mem_stage_type mem_q;
   wb_stage_type  wb_q;
   logic [31:0]   model_regs [32];
   logic [7:0]    model_dmem [DMEM_BYTES];

   rsp_type      cycle_reports [$];
   stim_row_type directed_rows [DIRECTED];

   int          cycle_count   = 0;
   int          mismatches    = 0;
   int          sent_count    = 0;
   int          preload_count = 0;
   int          reg_writes    = 0;
   int          stores        = 0;
   logic        send_steady   = 1'b0;
   logic        recv_steady   = 1'b0;
   logic [31:0] last_pc       = '0;

   mips_five_stage_pipeline_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_opcode            (req_opcode),
      .req_instr_word        (req_instr_word),
      .req_load_address      (req_load_address),
      .req_load_byte         (req_load_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_fetch_pc          (rsp_fetch_pc),
      .rsp_halted            (rsp_halted),
      .rsp_reg_write_valid   (rsp_reg_write_valid),
      .rsp_reg_write_index   (rsp_reg_write_index),
      .rsp_reg_write_data    (rsp_reg_write_data),
      .rsp_mem_write_valid   (rsp_mem_write_valid),
      .rsp_mem_write_address (rsp_mem_write_address),
      .rsp_mem_write_data    (rsp_mem_write_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [31:0] r_word(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                          logic [5:0] fn);
      return {OPC_RTYPE, rs, rt, rd, 5'b0, fn};
   endfunction

   function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic int dmem_index(logic [31:0] addr, int k);
      logic [63:0] sum;
      sum = {32'b0, addr} + 64'(k);
      return int'(sum % 64'(DMEM_BYTES));
   endfunction

   function automatic rsp_type advance_pipeline(logic op, logic [31:0] word,
                                                logic [7:0] load_addr, logic [7:0] load_val);
      rsp_type       r;
      dec_stage_type nd;
      exe_stage_type ne;
      mem_stage_type nm;
      wb_stage_type  nw;
      logic [31:0]   operand;
      logic [5:0]    opc;
      r  = '0;
      nd = dec_q;
      ne = exe_q;
      nm = mem_q;
      nw = wb_q;
      if (op == REQ_PRELOAD) begin
         model_dmem[int'(load_addr) % DMEM_BYTES] = load_val;
      end else begin
         if (!wb_q.bubble && wb_q.wr_reg && wb_q.dest != 5'd0) begin
            model_regs[wb_q.dest] = wb_q.data;
            r.reg_write_valid = 1'b1;
            r.reg_write_index = wb_q.dest;
            r.reg_write_data  = wb_q.data;
         end
         nw.bubble = mem_q.bubble;
         if (!mem_q.bubble) begin
            nw.data = mem_q.alu;
            if (mem_q.rd_mem) begin
               for (int k = 0; k < 4; k++)
                  nw.data = {nw.data[23:0], model_dmem[dmem_index(mem_q.alu, k)]};
            end else if (mem_q.wr_mem) begin
               for (int k = 0; k < 4; k++)
                  model_dmem[dmem_index(mem_q.alu, k)] = mem_q.store[31 - 8 * k -: 8];
               r.mem_write_valid   = 1'b1;
               r.mem_write_address = 8'(dmem_index(mem_q.alu, 0));
               r.mem_write_data    = mem_q.store;
            end
            nw.dest   = mem_q.dest;
            nw.wr_reg = mem_q.wr_reg;
         end
         nm.bubble = exe_q.bubble;
         if (!exe_q.bubble) begin
            operand   = exe_q.is_imm ? {{16{exe_q.imm[15]}}, exe_q.imm} : exe_q.opb;
            nm.alu    = exe_q.add ? exe_q.opa + operand : exe_q.opa - operand;
            nm.store  = exe_q.opb;
            nm.dest   = exe_q.dest;
            nm.rd_mem = exe_q.rd_mem;
            nm.wr_mem = exe_q.wr_mem;
            nm.wr_reg = exe_q.wr_reg;
         end
         ne.bubble = dec_q.bubble;
         if (!dec_q.bubble) begin
            opc       = dec_q.instr[31:26];
            ne.opa    = model_regs[dec_q.instr[25:21]];
            ne.opb    = model_regs[dec_q.instr[20:16]];
            ne.imm    = dec_q.instr[15:0];
            ne.is_imm = (opc != OPC_RTYPE);
            ne.add    = !(opc == OPC_RTYPE && dec_q.instr[5:0] == FN_SUBU);
            ne.dest   = ne.is_imm ? dec_q.instr[20:16] : dec_q.instr[15:11];
            ne.rd_mem = (opc == OPC_LW);
            ne.wr_mem = (opc == OPC_SW);
            ne.wr_reg = (opc == OPC_RTYPE) || (opc == OPC_LW);
         end
         nd.bubble = 1'b1;
         if (!model_fetch_done) begin
            if (word == HALT_WORD) begin
               model_fetch_done = 1'b1;
            end else begin
               nd.instr  = word;
               nd.bubble = 1'b0;
               model_pc  = model_pc + PC_STEP;
            end
         end
         dec_q = nd;
         exe_q = ne;
         mem_q = nm;
         wb_q  = nw;
      end
      r.fetch_pc = model_pc;
      r.halted   = model_fetch_done && dec_q.bubble && exe_q.bubble && mem_q.bubble &&
                   wb_q.bubble;
      return r;
   endfunction

   function automatic logic [4:0] base_reg();
      return ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom);
   endfunction

   function automatic stim_row_type random_row();
      stim_row_type s;
      int           pick;
      s        = '0;
      s.opcode = REQ_RUN;
      s.word   = $urandom;
      s.addr   = 8'($urandom);
      s.data   = 8'($urandom);
      pick     = $urandom_range(0, 99);
      if (pick < 8)
         s.opcode = REQ_PRELOAD;
      else if (pick < 30)
         s.word = i_word(OPC_LW, base_reg(), 5'($urandom), 16'($urandom));
      else if (pick < 45)
         s.word = i_word(OPC_SW, base_reg(), 5'($urandom), 16'($urandom));
      else if (pick < 65)
         s.word = r_word(5'($urandom), 5'($urandom), 5'($urandom), FN_ADDU);
      else if (pick < 80)
         s.word = r_word(5'($urandom), 5'($urandom), 5'($urandom), FN_SUBU);
      else if (pick < 86)
         s.word = r_word(5'($urandom), 5'($urandom), 5'($urandom), 6'($urandom));
      else if (pick < 92)
         s.word[31:26] = 6'($urandom_range(1, 63));
      if (s.word == HALT_WORD)
         s.word = r_word(5'd0, 5'd0, 5'd0, FN_ADDU);
      return s;
   endfunction

   task automatic send_item(input stim_row_type row);
      int      gap;
      rsp_type want;
      if ($urandom_range(0, 39) == 0)
         send_steady = !send_steady;
      gap = send_steady ? 0 : $urandom_range(0, 16);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= row.opcode;
      req_instr_word   <= row.word;
      req_load_address <= row.addr;
      req_load_byte    <= row.data;
      do @(posedge clock); while (req_stall !== 1'b0);
      want = advance_pipeline(row.opcode, row.word, row.addr, row.data);
      if (row.typed) begin
         want          = '0;
         want.fetch_pc = row.typed_pc;
      end
      cycle_reports.push_back(want);
      sent_count++;
      if (row.opcode == REQ_PRELOAD)
         preload_count++;
      reg_writes += want.reg_write_valid;
      stores     += want.mem_write_valid;
      last_pc     = want.fetch_pc;
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch in %s at cycle %0d: expected %h, got %h",
                     name, cycle_count, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = {rsp_fetch_pc, rsp_halted, rsp_reg_write_valid, rsp_reg_write_index,
                rsp_reg_write_data, rsp_mem_write_valid, rsp_mem_write_address,
                rsp_mem_write_data};
         if (cycle_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction at cycle %0d: %h", cycle_count, got);
         end else begin
            want = cycle_reports.pop_front();
            check_field("fetch_pc", want.fetch_pc, got.fetch_pc);
            check_field("halted", 32'(want.halted), 32'(got.halted));
            check_field("reg_write_valid", 32'(want.reg_write_valid),
                        32'(got.reg_write_valid));
            check_field("reg_write_index", 32'(want.reg_write_index),
                        32'(got.reg_write_index));
            check_field("reg_write_data", want.reg_write_data, got.reg_write_data);
            check_field("mem_write_valid", 32'(want.mem_write_valid),
                        32'(got.mem_write_valid));
            check_field("mem_write_address", 32'(want.mem_write_address),
                        32'(got.mem_write_address));
            check_field("mem_write_data", want.mem_write_data, got.mem_write_data);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         if ($urandom_range(0, 39) == 0)
            recv_steady = !recv_steady;
         hold = recv_steady ? 0 : $urandom_range(0, 16);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
      end
   end

   initial begin
      stim_row_type row;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = REQ_RUN;
      req_instr_word   = '0;
      req_load_address = '0;
      req_load_byte    = '0;

      model_pc         = '0;
      model_fetch_done = 1'b0;
      dec_q            = '0;
      dec_q.bubble     = 1'b1;
      exe_q            = '0;
      exe_q.bubble     = 1'b1;
      exe_q.add        = 1'b1;
      mem_q            = '0;
      mem_q.bubble     = 1'b1;
      wb_q             = '0;
      wb_q.bubble      = 1'b1;
      foreach (model_regs[i])
         model_regs[i] = '0;
      foreach (model_dmem[i])
         model_dmem[i] = '0;

      // Rows with typed set carry the response that follows reset directly.
      directed_rows = '{
         '{REQ_PRELOAD, 32'h0, 8'h00, 8'h80, 1'b1, 32'd0},
         '{REQ_PRELOAD, 32'h0, 8'hFF, 8'hFF, 1'b1, 32'd0},
         '{REQ_PRELOAD, 32'h0, 8'h03, 8'h01, 1'b1, 32'd0},
         '{REQ_RUN, i_word(OPC_LW, 5'd0, 5'd1, 16'h0000), 8'h00, 8'h00, 1'b1, 32'd4},
         '{REQ_RUN, i_word(OPC_LW, 5'd0, 5'd2, 16'hFFFF), 8'hFF, 8'hFF, 1'b0, 32'd0},
         '{REQ_RUN, i_word(OPC_LW, 5'd0, 5'd31, 16'h7FFF), 8'h00, 8'h00, 1'b0, 32'd0},
         '{REQ_RUN, r_word(5'd0, 5'd0, 5'd0, FN_ADDU), 8'h00, 8'h00, 1'b0, 32'd0},
         '{REQ_RUN, r_word(5'd1, 5'd2, 5'd3, FN_ADDU), 8'h00, 8'h00, 1'b0, 32'd0},
         '{REQ_RUN, r_word(5'd1, 5'd2, 5'd4, FN_SUBU), 8'h00, 8'h00, 1'b0, 32'd0},
         '{REQ_RUN, r_word(5'd31, 5'd31, 5'd5, FN_OTHER), 8'h00, 8'h00, 1'b0, 32'd0},
         '{REQ_PRELOAD, 32'hFFFF_FFFF, 8'h80, 8'hAA, 1'b0, 32'd0},
         '{REQ_RUN, i_word(OPC_SW, 5'd0, 5'd3, 16'hFFFC), 8'h00, 8'h00, 1'b0, 32'd0},
         '{REQ_RUN, i_word(OPC_SW, 5'd0, 5'd31, 16'h00FE), 8'h00, 8'h00, 1'b0, 32'd0},
         '{REQ_RUN, i_word(OPC_ADDI, 5'd0, 5'd1, 16'hFFFF), 8'h00, 8'h00, 1'b0, 32'd0},
         '{REQ_RUN, i_word(~OPC_RTYPE, 5'd31, 5'd31, 16'hFFFE), 8'h00, 8'h00, 1'b0, 32'd0},
         '{REQ_RUN, 32'h0000_0000, 8'h00, 8'h00, 1'b0, 32'd0},
         '{REQ_RUN, i_word(OPC_LW, 5'd0, 5'd0, 16'h0004), 8'h00, 8'h00, 1'b0, 32'd0},
         '{REQ_RUN, r_word(5'd3, 5'd4, 5'd6, FN_SUBU), 8'h00, 8'h00, 1'b0, 32'd0},
         '{REQ_RUN, i_word(OPC_LW, 5'd0, 5'd7, 16'h00FC), 8'h00, 8'h00, 1'b0, 32'd0},
         '{REQ_RUN, r_word(5'd7, 5'd7, 5'd8, FN_ADDU), 8'h00, 8'h00, 1'b0, 32'd0},
         '{REQ_PRELOAD, 32'h0, 8'h00, 8'h00, 1'b0, 32'd0},
         '{REQ_RUN, r_word(5'd0, 5'd0, 5'd0, FN_ADDU), 8'h00, 8'h00, 1'b0, 32'd0},
         '{REQ_RUN, r_word(5'd0, 5'd0, 5'd0, FN_ADDU), 8'h00, 8'h00, 1'b0, 32'd0},
         '{REQ_RUN, r_word(5'd0, 5'd0, 5'd0, FN_ADDU), 8'h00, 8'h00, 1'b0, 32'd0}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < DIRECTED; k++)
         send_item(directed_rows[k]);
      for (int k = 0; k < RANDOM_ITEMS; k++)
         send_item(random_row());

      // Wait until every expected response has been received before the halt word goes in.
      req_valid <= 1'b0;
      do @(posedge clock); while (cycle_reports.size() != 0);

      row        = random_row();
      row.opcode = REQ_RUN;
      row.word   = HALT_WORD;
      send_item(row);
      for (int k = 0; k < 8; k++) begin
         row        = random_row();
         row.opcode = REQ_RUN;
         row.word   = $urandom;
         send_item(row);
      end
      row        = random_row();
      row.opcode = REQ_PRELOAD;
      send_item(row);
      req_valid <= 1'b0;

      do @(posedge clock); while (cycle_reports.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d transactions (%0d preloads); the pipeline wrote %0d registers",
               sent_count, preload_count, reg_writes);
      $display("and %0d memory words, then halted with fetch at %h; %0d mismatches.",
               stores, last_pc, mismatches);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
